// File: design/mm64b_pkg.sv
// mm64b_pkg: shared constants, types and the 32-bit modular multiply for the
// MurmurHash64B core. No dependencies; used by every module of the core.
package mm64b_pkg;

  localparam int LENGTH_BITS = 16;

  localparam logic [31:0] MIX_MUL    = 32'h5bd1e995;
  localparam int          MIX_SHIFT  = 24;
  localparam logic [31:0] SEED_RESET = 32'hEE6B27EB;

  localparam int FIN_SHIFT_1 = 18;
  localparam int FIN_SHIFT_2 = 22;
  localparam int FIN_SHIFT_3 = 17;
  localparam int FIN_SHIFT_4 = 19;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // what a word does to the accumulators
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_FULL = 2'd1,
    KIND_PART = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [31:0]            value;
    logic                   first;
    logic                   last;
    logic [LENGTH_BITS-1:0] len;
  } entry_t;

  typedef enum logic [4:0] {
    ST_ACC = 5'b00001,
    ST_F1  = 5'b00010,
    ST_F2  = 5'b00100,
    ST_F3  = 5'b01000,
    ST_F4  = 5'b10000
  } state_t;

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

endpackage

// File: design/murmur64b_hash_core.sv
// MurmurHash64B streaming core: words enter a two-stage mixing front end, pass
// through a four-word queue and are folded into the accumulators by the back
// end at one word per cycle, except while it runs the four finalization rounds
// on its single 32x32 multiplier after the word marked last. It takes no new
// word until the 64-bit hash (h1 in bits 63:32) appears in the output register,
// and the last round waits while the output register is full and stalled. The
// seed port is always ready and must only be written while the core is idle.
// Depends on mm64b_pkg, mm64b_front, mm64b_queue and mm64b_back.
module murmur64b_hash_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_valid,
  output logic        seed_ready,
  input  logic [31:0] seed,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        first,
  input  logic        last,
  input  logic [15:0] total_length,
  input  logic        in_valid,
  output logic        in_stall,
  output logic [63:0] hash_value,
  output logic        out_valid,
  input  logic        out_stall
);

  logic [31:0]       seed_reg;
  logic              push_valid;
  logic              push_ready;
  mm64b_pkg::entry_t push_data;
  logic              pop_valid;
  logic              pop_ready;
  mm64b_pkg::entry_t pop_data;

  assign seed_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_reg <= mm64b_pkg::SEED_RESET;
    end else if (seed_valid && seed_ready) begin
      seed_reg <= seed;
    end
  end

  mm64b_front u_front (
    .clk          (clk),
    .rst          (rst),
    .data_word    (data_word),
    .byte_count   (byte_count),
    .first        (first),
    .last         (last),
    .total_length (total_length),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .push_valid   (push_valid),
    .push_data    (push_data),
    .push_ready   (push_ready)
  );

  mm64b_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  mm64b_back u_back (
    .clk        (clk),
    .rst        (rst),
    .seed       (seed_reg),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready),
    .hash_value (hash_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

endmodule

// File: design/mm64b_front.sv
// mm64b_front: accepts input words, classifies them and mixes full words in a
// two-stage multiply pipeline. Depends on mm64b_pkg.
module mm64b_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [31:0]            data_word,
  input  logic [2:0]             byte_count,
  input  logic                   first,
  input  logic                   last,
  input  logic [15:0]            total_length,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   push_valid,
  output mm64b_pkg::entry_t      push_data,
  input  logic                   push_ready
);

  localparam int LB = mm64b_pkg::LENGTH_BITS;

  logic              s1_valid;
  logic              s2_valid;
  mm64b_pkg::entry_t s1;
  mm64b_pkg::entry_t s2;
  mm64b_pkg::entry_t in_entry;
  mm64b_pkg::entry_t s2_entry;
  logic [31:0]       keep;
  logic [31:0]       t;
  logic              s1_free;
  logic              s2_free;

  assign s2_free  = !s2_valid || push_ready;
  assign s1_free  = !s1_valid || s2_free;
  assign in_stall = !s1_free;

  assign push_valid = s2_valid;
  assign push_data  = s2;

  always_comb begin
    priority if (byte_count == 3'd3) begin
      keep = 32'h00FFFFFF;
    end else if (byte_count == 3'd2) begin
      keep = 32'h0000FFFF;
    end else begin
      keep = 32'h000000FF;
    end

    in_entry.first = first;
    in_entry.last  = last;
    in_entry.len   = LB'(total_length);
    priority if (byte_count >= 3'd4) begin
      in_entry.kind  = mm64b_pkg::KIND_FULL;
      in_entry.value = mm64b_pkg::mul32(data_word, mm64b_pkg::MIX_MUL);
    end else if (byte_count == 3'd0) begin
      in_entry.kind  = mm64b_pkg::KIND_NONE;
      in_entry.value = data_word;
    end else begin
      in_entry.kind  = mm64b_pkg::KIND_PART;
      in_entry.value = data_word & keep;
    end
  end

  // second half of the word mix: xor-shift then multiply
  always_comb begin
    t        = s1.value ^ (s1.value >> mm64b_pkg::MIX_SHIFT);
    s2_entry = s1;
    if (s1.kind == mm64b_pkg::KIND_FULL) begin
      s2_entry.value = mm64b_pkg::mul32(t, mm64b_pkg::MIX_MUL);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= in_valid;
        if (in_valid) begin
          s1 <= in_entry;
        end
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
        if (s1_valid) begin
          s2 <= s2_entry;
        end
      end
    end
  end

endmodule

// File: design/mm64b_queue.sv
// mm64b_queue: short word queue between the mixing front end and the
// accumulator back end. Depends on mm64b_pkg.
module mm64b_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  mm64b_pkg::entry_t push_data,
  output logic              push_ready,
  output logic              pop_valid,
  output mm64b_pkg::entry_t pop_data,
  input  logic              pop_ready
);

  localparam int PW = mm64b_pkg::QPTR_W;

  mm64b_pkg::entry_t slots [mm64b_pkg::QDEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [PW:0]       count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != (PW+1)'(mm64b_pkg::QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        slots[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == PW'(mm64b_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(mm64b_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/mm64b_back.sv
// mm64b_back: folds mixed words into the two accumulators and runs the
// four-round finalization on one shared multiplier. Depends on mm64b_pkg.
module mm64b_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       seed,
  input  logic              pop_valid,
  input  mm64b_pkg::entry_t pop_data,
  output logic              pop_ready,
  output logic [63:0]       hash_value,
  output logic              out_valid,
  input  logic              out_stall
);

  mm64b_pkg::state_t state;
  logic [31:0]       acc_high;
  logic [31:0]       acc_low;
  logic              next_is_low;
  logic [31:0]       f1;
  logic [31:0]       f2;

  logic [31:0] base_h;
  logic [31:0] base_l;
  logic        base_n;
  logic [31:0] mul_op;
  logic [31:0] prod;
  logic [31:0] acc_high_next;
  logic [31:0] acc_low_next;
  logic        next_is_low_next;
  logic        out_free;

  assign pop_ready = state == mm64b_pkg::ST_ACC;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    // a first word restarts from seed ^ length
    base_h = pop_data.first ? (seed ^ 32'(pop_data.len)) : acc_high;
    base_l = pop_data.first ? 32'd0 : acc_low;
    base_n = pop_data.first ? 1'b0 : next_is_low;

    unique case (state)
      mm64b_pkg::ST_ACC: begin
        if (pop_data.kind == mm64b_pkg::KIND_FULL) begin
          mul_op = base_n ? base_l : base_h;
        end else begin
          mul_op = base_l ^ pop_data.value;
        end
      end
      mm64b_pkg::ST_F1: mul_op = f1 ^ (f2 >> mm64b_pkg::FIN_SHIFT_1);
      mm64b_pkg::ST_F2: mul_op = f2 ^ (f1 >> mm64b_pkg::FIN_SHIFT_2);
      mm64b_pkg::ST_F3: mul_op = f1 ^ (f2 >> mm64b_pkg::FIN_SHIFT_3);
      mm64b_pkg::ST_F4: mul_op = f2 ^ (f1 >> mm64b_pkg::FIN_SHIFT_4);
      default:          mul_op = 32'd0;
    endcase
    prod = mm64b_pkg::mul32(mul_op, mm64b_pkg::MIX_MUL);

    acc_high_next    = base_h;
    acc_low_next     = base_l;
    next_is_low_next = base_n;
    unique case (pop_data.kind)
      mm64b_pkg::KIND_FULL: begin
        if (base_n) begin
          acc_low_next = prod ^ pop_data.value;
        end else begin
          acc_high_next = prod ^ pop_data.value;
        end
        next_is_low_next = !base_n;
      end
      mm64b_pkg::KIND_PART: acc_low_next = prod;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= mm64b_pkg::ST_ACC;
      acc_high    <= '0;
      acc_low     <= '0;
      next_is_low <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (state == mm64b_pkg::ST_F4 && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        mm64b_pkg::ST_ACC: begin
          if (pop_valid) begin
            acc_high    <= acc_high_next;
            acc_low     <= acc_low_next;
            next_is_low <= next_is_low_next;
            if (pop_data.last) begin
              // finalization works on copies
              f1    <= acc_high_next;
              f2    <= acc_low_next;
              state <= mm64b_pkg::ST_F1;
            end
          end
        end
        mm64b_pkg::ST_F1: begin
          f1    <= prod;
          state <= mm64b_pkg::ST_F2;
        end
        mm64b_pkg::ST_F2: begin
          f2    <= prod;
          state <= mm64b_pkg::ST_F3;
        end
        mm64b_pkg::ST_F3: begin
          f1    <= prod;
          state <= mm64b_pkg::ST_F4;
        end
        mm64b_pkg::ST_F4: begin
          if (out_free) begin
            hash_value <= {f1, prod};
            state      <= mm64b_pkg::ST_ACC;
          end
        end
        default: state <= mm64b_pkg::ST_ACC;
      endcase
    end
  end

endmodule
